/* rtl/adt_pkg.sv */
`timescale 1ns / 1ps

package adt_pkg;

   // Table geometry
   localparam int DEFAULT_TABLE_DEPTH = 256;

   // Field widths
   localparam int ADDR_W     = 48;
   localparam int STRENGTH_W = 8;
   localparam int COUNT_W    = 16;
   localparam int TIME_W     = 32;
   localparam int DWELL_W    = 23;
   localparam int SCORE_W    = 24;
   localparam int TOTAL_W    = 9;
   localparam int MARKS_W    = 16;

   // Scoring and saturation constants
   localparam logic [COUNT_W-1:0] COUNT_MAX       = 16'hFFFF;
   localparam logic [MARKS_W-1:0] MARKS_MAX       = 16'hFFFF;
   localparam int                 CROSS_BONUS     = 5000;
   localparam int                 RANDOM_PENALTY  = 30;
   localparam int                 STRENGTH_OFFSET = 100;

   // Millisecond span to seconds: x / 1000 = (x * 274877907) >> 38,
   // exact for every 32-bit x
   localparam int                 MS_PER_S  = 1000;
   localparam int                 RECIP_W   = 29;
   localparam logic [RECIP_W-1:0] DIV_RECIP = 29'd274877907;
   localparam int                 DIV_SHIFT = 38;
   localparam int                 PROD_W    = TIME_W + RECIP_W;

   localparam logic ACTION_SIGHT = 1'b0;
   localparam logic ACTION_MOVE  = 1'b1;

   // One stored table entry (insert rank is kept beside it, its width is per depth)
   typedef struct packed {
      logic [ADDR_W-1:0]            addr;
      logic                         source;
      logic signed [STRENGTH_W-1:0] last_strength;
      logic signed [STRENGTH_W-1:0] best_strength;
      logic [COUNT_W-1:0]           count;
      logic [TIME_W-1:0]            first_ms;
      logic [TIME_W-1:0]            last_ms;
      logic                         random;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_MATCH,
      ST_PREP_OLD,
      ST_OLDEST,
      ST_EVICT,
      ST_DECR,
      ST_WRITE,
      ST_DIV,
      ST_SCORE,
      ST_MOVE,
      ST_RESPOND
   } ctl_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MATCH,
      OP_RESTART,
      OP_OLDEST,
      OP_EVICT,
      OP_DECR,
      OP_WRITE,
      OP_DIV,
      OP_SCORE,
      OP_MOVE
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic found;
      logic full;
      logic is_move;
   } dp_status_type;

endpackage

/* rtl/adt_ram.sv */
`timescale 1ns / 1ps

module adt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/adt_datapath.sv */
`timescale 1ns / 1ps

module adt_datapath import adt_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dp_cmd_type                   cmd,
   output dp_status_type                status,
   input  logic                         req_action,
   input  logic [ADDR_W-1:0]            req_address,
   input  logic                         req_source,
   input  logic signed [STRENGTH_W-1:0] req_signal_strength,
   input  logic                         req_random_address,
   input  logic [TIME_W-1:0]            req_now_ms,
   output logic                         rsp_hit,
   output logic                         rsp_evicted,
   output logic                         rsp_crossed_now,
   output logic [COUNT_W-1:0]           rsp_sighting_count,
   output logic signed [STRENGTH_W-1:0] rsp_best_strength,
   output logic [DWELL_W-1:0]           rsp_dwell_seconds,
   output logic signed [SCORE_W-1:0]    rsp_follower_score,
   output logic [TOTAL_W-1:0]           rsp_follower_total,
   output logic [TOTAL_W-1:0]           rsp_tracked_total,
   output logic [MARKS_W-1:0]           rsp_move_marks
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [IW:0]   SCAN_END   = (IW + 1)'(TABLE_DEPTH);
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

   typedef struct packed {
      logic [IW-1:0] rank;
      entry_type     ent;
   } word_type;

   // Table word store
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   word_type      wr_data;
   logic [IW-1:0] rd_addr;
   word_type      rd_word;

   adt_ram #(
      .WIDTH ($bits(word_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   // Control state
   logic [IW:0]             issue_ff, issue_in;
   logic                    pend_ff, pend_in;
   logic [IW-1:0]           pend_idx_ff, pend_idx_in;
   logic                    found_ff, found_in;
   logic                    free_found_ff, free_found_in;
   logic                    old_found_ff, old_found_in;
   logic [TABLE_DEPTH-1:0]  valid_ff, valid_in;
   logic [TABLE_DEPTH-1:0]  before_ff, before_in;
   logic [TABLE_DEPTH-1:0]  after_ff, after_in;
   logic [CW-1:0]           live_ff, live_in;
   logic [CW-1:0]           fol_cnt_ff, fol_cnt_in;
   logic [MARKS_W-1:0]      move_cnt_ff, move_cnt_in;
   logic                    move_seen_ff, move_seen_in;

   // Payload state
   logic [IW-1:0]                slot_ff, slot_in;
   logic [IW-1:0]                free_ff, free_in;
   logic [IW-1:0]                old_idx_ff, old_idx_in;
   logic [TIME_W-1:0]            old_last_ff, old_last_in;
   logic [IW-1:0]                old_rank_ff, old_rank_in;
   word_type                     cur_ff, cur_in;
   logic                         act_ff, act_in;
   logic [ADDR_W-1:0]            addr_ff, addr_in;
   logic                         src_ff, src_in;
   logic signed [STRENGTH_W-1:0] str_ff, str_in;
   logic                         rnd_ff, rnd_in;
   logic [TIME_W-1:0]            now_ff, now_in;
   logic [TIME_W-1:0]            num_ff, num_in;
   logic                         hit_ff, hit_in;
   logic                         evicted_ff, evicted_in;
   logic                         crossed_ff, crossed_in;
   logic [COUNT_W-1:0]           cnt_ff, cnt_in;
   logic signed [STRENGTH_W-1:0] best_ff, best_in;
   logic [DWELL_W-1:0]           dwell_ff, dwell_in;
   logic signed [SCORE_W-1:0]    score_ff, score_in;
   logic                         res_rnd_ff, res_rnd_in;
   logic                         res_fol_ff, res_fol_in;

   // Next state for every command
   always_comb begin
      word_type                  w;
      logic                      crossing;
      logic [TIME_W-1:0]         first_sel;
      logic [PROD_W-1:0]         prod;
      logic signed [SCORE_W-1:0] sc;

      issue_in      = issue_ff;
      pend_in       = 1'b0;
      pend_idx_in   = issue_ff[IW-1:0];
      found_in      = found_ff;
      free_found_in = free_found_ff;
      old_found_in  = old_found_ff;
      valid_in      = valid_ff;
      before_in     = before_ff;
      after_in      = after_ff;
      live_in       = live_ff;
      fol_cnt_in    = fol_cnt_ff;
      move_cnt_in   = move_cnt_ff;
      move_seen_in  = move_seen_ff;
      slot_in       = slot_ff;
      free_in       = free_ff;
      old_idx_in    = old_idx_ff;
      old_last_in   = old_last_ff;
      old_rank_in   = old_rank_ff;
      cur_in        = cur_ff;
      act_in        = act_ff;
      addr_in       = addr_ff;
      src_in        = src_ff;
      str_in        = str_ff;
      rnd_in        = rnd_ff;
      now_in        = now_ff;
      num_in        = num_ff;
      hit_in        = hit_ff;
      evicted_in    = evicted_ff;
      crossed_in    = crossed_ff;
      cnt_in        = cnt_ff;
      best_in       = best_ff;
      dwell_in      = dwell_ff;
      score_in      = score_ff;
      res_rnd_in    = res_rnd_ff;
      res_fol_in    = res_fol_ff;

      wr_en   = 1'b0;
      wr_addr = pend_idx_ff;
      wr_data = rd_word;
      rd_addr = issue_ff[IW-1:0];

      w         = cur_ff;
      crossing  = 1'b0;
      first_sel = now_ff;
      prod      = '0;
      sc        = '0;

      case (cmd.op)
         // Capture the beat and rewind the scan
         OP_LOAD: begin
            act_in        = req_action;
            addr_in       = req_address;
            src_in        = req_source;
            str_in        = req_signal_strength;
            rnd_in        = req_random_address;
            now_in        = req_now_ms;
            issue_in      = '0;
            found_in      = 1'b0;
            free_found_in = 1'b0;
            hit_in        = 1'b0;
            evicted_in    = 1'b0;
            crossed_in    = 1'b0;
         end
         OP_RESTART: begin
            issue_in     = '0;
            old_found_in = 1'b0;
         end
         // Look for the address; note the first free slot on the way
         OP_MATCH: begin
            if (!found_ff && issue_ff != SCAN_END) begin
               issue_in = issue_ff + (IW + 1)'(1);
               pend_in  = 1'b1;
            end
            if (pend_ff && !found_ff) begin
               if (valid_ff[pend_idx_ff] && rd_word.ent.addr == addr_ff) begin
                  found_in = 1'b1;
                  slot_in  = pend_idx_ff;
                  cur_in   = rd_word;
               end else if (!valid_ff[pend_idx_ff] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_in       = pend_idx_ff;
               end
            end
         end
         // Oldest last-seen time, earliest insert on ties
         OP_OLDEST: begin
            if (issue_ff != SCAN_END) begin
               issue_in = issue_ff + (IW + 1)'(1);
               pend_in  = 1'b1;
            end
            if (pend_ff && valid_ff[pend_idx_ff]) begin
               if (!old_found_ff || rd_word.ent.last_ms < old_last_ff ||
                   (rd_word.ent.last_ms == old_last_ff && rd_word.rank < old_rank_ff)) begin
                  old_found_in = 1'b1;
                  old_idx_in   = pend_idx_ff;
                  old_last_in  = rd_word.ent.last_ms;
                  old_rank_in  = rd_word.rank;
               end
            end
         end
         OP_EVICT: begin
            valid_in[old_idx_ff] = 1'b0;
            live_in              = live_ff - CW'(1);
            if (before_ff[old_idx_ff] && after_ff[old_idx_ff]) begin
               fol_cnt_in = fol_cnt_ff - CW'(1);
            end
            evicted_in = 1'b1;
            free_in    = old_idx_ff;
            issue_in   = '0;
         end
         // Close the gap in insert order left by the evicted entry
         OP_DECR: begin
            if (issue_ff != SCAN_END) begin
               issue_in = issue_ff + (IW + 1)'(1);
               pend_in  = 1'b1;
            end
            if (pend_ff && valid_ff[pend_idx_ff] && rd_word.rank > old_rank_ff) begin
               wr_en        = 1'b1;
               wr_data      = rd_word;
               wr_data.rank = rd_word.rank - IW'(1);
            end
         end
         // Update a hit or insert a new entry
         OP_WRITE: begin
            if (found_ff) begin
               w                   = cur_ff;
               w.ent.last_strength = str_ff;
               if (str_ff > cur_ff.ent.best_strength) begin
                  w.ent.best_strength = str_ff;
               end
               w.ent.last_ms = now_ff;
               if (cur_ff.ent.count != COUNT_MAX) begin
                  w.ent.count = cur_ff.ent.count + COUNT_W'(1);
               end
               crossing = move_seen_ff && before_ff[slot_ff] && !after_ff[slot_ff];
               if (crossing) begin
                  after_in[slot_ff] = 1'b1;
                  fol_cnt_in        = fol_cnt_ff + CW'(1);
               end
               hit_in     = 1'b1;
               crossed_in = crossing;
               res_fol_in = before_ff[slot_ff] && (after_ff[slot_ff] || crossing);
               wr_addr    = slot_ff;
               first_sel  = cur_ff.ent.first_ms;
            end else begin
               w.rank              = live_ff[IW-1:0];
               w.ent.addr          = addr_ff;
               w.ent.source        = src_ff;
               w.ent.last_strength = str_ff;
               w.ent.best_strength = str_ff;
               w.ent.count         = COUNT_W'(1);
               w.ent.first_ms      = now_ff;
               w.ent.last_ms       = now_ff;
               w.ent.random        = rnd_ff;
               valid_in[free_ff]   = 1'b1;
               before_in[free_ff]  = 1'b0;
               after_in[free_ff]   = 1'b0;
               live_in             = live_ff + CW'(1);
               res_fol_in          = 1'b0;
               wr_addr             = free_ff;
               first_sel           = now_ff;
            end
            wr_en      = 1'b1;
            wr_data    = w;
            cnt_in     = w.ent.count;
            best_in    = w.ent.best_strength;
            res_rnd_in = w.ent.random;
            num_in     = now_ff - first_sel;
         end
         // Span to seconds by reciprocal multiply
         OP_DIV: begin
            prod   = PROD_W'(num_ff) * PROD_W'(DIV_RECIP);
            num_in = TIME_W'(prod[PROD_W-1:DIV_SHIFT]);
         end
         OP_SCORE: begin
            sc = SCORE_W'(num_ff[DWELL_W-1:0]) + SCORE_W'(cnt_ff)
               + {{(SCORE_W - STRENGTH_W){best_ff[STRENGTH_W-1]}}, best_ff}
               + SCORE_W'(STRENGTH_OFFSET);
            if (res_fol_ff) begin
               sc = sc + SCORE_W'(CROSS_BONUS);
            end
            if (res_rnd_ff) begin
               sc = sc - SCORE_W'(RANDOM_PENALTY);
            end
            dwell_in = num_ff[DWELL_W-1:0];
            score_in = sc;
         end
         // Move mark: every live entry becomes before-move
         OP_MOVE: begin
            move_seen_in = 1'b1;
            if (move_cnt_ff != MARKS_MAX) begin
               move_cnt_in = move_cnt_ff + MARKS_W'(1);
            end
            before_in  = before_ff | valid_ff;
            after_in   = after_ff & ~valid_ff;
            fol_cnt_in = '0;
            cnt_in     = '0;
            best_in    = '0;
            dwell_in   = '0;
            score_in   = '0;
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff      <= '0;
         pend_ff       <= 1'b0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         old_found_ff  <= 1'b0;
         valid_ff      <= '0;
         before_ff     <= '0;
         after_ff      <= '0;
         live_ff       <= '0;
         fol_cnt_ff    <= '0;
         move_cnt_ff   <= '0;
         move_seen_ff  <= 1'b0;
      end else begin
         issue_ff      <= issue_in;
         pend_ff       <= pend_in;
         found_ff      <= found_in;
         free_found_ff <= free_found_in;
         old_found_ff  <= old_found_in;
         valid_ff      <= valid_in;
         before_ff     <= before_in;
         after_ff      <= after_in;
         live_ff       <= live_in;
         fol_cnt_ff    <= fol_cnt_in;
         move_cnt_ff   <= move_cnt_in;
         move_seen_ff  <= move_seen_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      slot_ff     <= slot_in;
      free_ff     <= free_in;
      old_idx_ff  <= old_idx_in;
      old_last_ff <= old_last_in;
      old_rank_ff <= old_rank_in;
      cur_ff      <= cur_in;
      act_ff      <= act_in;
      addr_ff     <= addr_in;
      src_ff      <= src_in;
      str_ff      <= str_in;
      rnd_ff      <= rnd_in;
      now_ff      <= now_in;
      num_ff      <= num_in;
      hit_ff      <= hit_in;
      evicted_ff  <= evicted_in;
      crossed_ff  <= crossed_in;
      cnt_ff      <= cnt_in;
      best_ff     <= best_in;
      dwell_ff    <= dwell_in;
      score_ff    <= score_in;
      res_rnd_ff  <= res_rnd_in;
      res_fol_ff  <= res_fol_in;
   end

   // Status to the controller
   assign status.scan_done = (issue_ff == SCAN_END && !pend_ff) || found_ff;
   assign status.found     = found_ff;
   assign status.full      = (live_ff == FULL_COUNT);
   assign status.is_move   = (act_ff == ACTION_MOVE);

   // Result beat
   assign rsp_hit            = hit_ff;
   assign rsp_evicted        = evicted_ff;
   assign rsp_crossed_now    = crossed_ff;
   assign rsp_sighting_count = cnt_ff;
   assign rsp_best_strength  = best_ff;
   assign rsp_dwell_seconds  = dwell_ff;
   assign rsp_follower_score = score_ff;
   assign rsp_follower_total = TOTAL_W'(fol_cnt_ff);
   assign rsp_tracked_total  = TOTAL_W'(live_ff);
   assign rsp_move_marks     = move_cnt_ff;

endmodule

/* rtl/adt_controller.sv */
`timescale 1ns / 1ps

module adt_controller import adt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctl_state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            state_in = status.is_move ? ST_MOVE : ST_MATCH;
         end
         ST_MATCH: begin
            if (status.scan_done) begin
               if (status.found || !status.full) state_in = ST_WRITE;
               else                              state_in = ST_PREP_OLD;
            end
         end
         ST_PREP_OLD: state_in = ST_OLDEST;
         ST_OLDEST: begin
            if (status.scan_done) state_in = ST_EVICT;
         end
         ST_EVICT: state_in = ST_DECR;
         ST_DECR: begin
            if (status.scan_done) state_in = ST_WRITE;
         end
         ST_WRITE: state_in = ST_DIV;
         ST_DIV:   state_in = ST_SCORE;
         ST_SCORE: state_in = ST_RESPOND;
         ST_MOVE:  state_in = ST_RESPOND;
         ST_RESPOND: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd.op    = OP_NONE;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) cmd.op = OP_LOAD;
         end
         ST_DISPATCH: cmd.op = OP_NONE;
         ST_MATCH:    cmd.op = OP_MATCH;
         ST_PREP_OLD: cmd.op = OP_RESTART;
         ST_OLDEST:   cmd.op = OP_OLDEST;
         ST_EVICT:    cmd.op = OP_EVICT;
         ST_DECR:     cmd.op = OP_DECR;
         ST_WRITE:    cmd.op = OP_WRITE;
         ST_DIV:      cmd.op = OP_DIV;
         ST_SCORE:    cmd.op = OP_SCORE;
         ST_MOVE:     cmd.op = OP_MOVE;
         ST_RESPOND:  rsp_valid = 1'b1;
         default:     cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/address_dwell_tracker_core.sv */
`timescale 1ns / 1ps

// Dwell tracker for radio sightings. One beat in gives one beat out, one item
// at a time. The table is a word store with one write port and one registered
// read port, scanned one entry per cycle; the match scan stops at a hit. A hit
// or a miss with free room needs only the match scan; a miss on a full table
// adds an oldest-entry scan and an insert-order repair scan; a move mark needs
// no scan. Output stalls add to the time. The divide by 1000 is a single
// reciprocal multiply.
// No input is taken until the previous result beat has gone.
// No clearing pass is needed after reset; the table is usable at once.

module address_dwell_tracker_core import adt_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_action,
   input  logic [ADDR_W-1:0]            req_address,
   input  logic                         req_source,
   input  logic signed [STRENGTH_W-1:0] req_signal_strength,
   input  logic                         req_random_address,
   input  logic [TIME_W-1:0]            req_now_ms,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_hit,
   output logic                         rsp_evicted,
   output logic                         rsp_crossed_now,
   output logic [COUNT_W-1:0]           rsp_sighting_count,
   output logic signed [STRENGTH_W-1:0] rsp_best_strength,
   output logic [DWELL_W-1:0]           rsp_dwell_seconds,
   output logic signed [SCORE_W-1:0]    rsp_follower_score,
   output logic [TOTAL_W-1:0]           rsp_follower_total,
   output logic [TOTAL_W-1:0]           rsp_tracked_total,
   output logic [MARKS_W-1:0]           rsp_move_marks
);

   dp_cmd_type    cmd;
   dp_status_type status;

   adt_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   adt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_action          (req_action),
      .req_address         (req_address),
      .req_source          (req_source),
      .req_signal_strength (req_signal_strength),
      .req_random_address  (req_random_address),
      .req_now_ms          (req_now_ms),
      .rsp_hit             (rsp_hit),
      .rsp_evicted         (rsp_evicted),
      .rsp_crossed_now     (rsp_crossed_now),
      .rsp_sighting_count  (rsp_sighting_count),
      .rsp_best_strength   (rsp_best_strength),
      .rsp_dwell_seconds   (rsp_dwell_seconds),
      .rsp_follower_score  (rsp_follower_score),
      .rsp_follower_total  (rsp_follower_total),
      .rsp_tracked_total   (rsp_tracked_total),
      .rsp_move_marks      (rsp_move_marks)
   );

   // No new beat is taken while a result waits
   a_no_accept_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted while a result beat is pending");

   // A crossing can only come from a hit
   a_cross_needs_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_crossed_now) |-> rsp_hit)
      else $error("crossing reported without a hit");

   // A hit never evicts
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> !rsp_evicted)
      else $error("eviction reported on a hit");

endmodule
